@@ sv/msk_pkg.sv @@
`default_nettype none

package msk_pkg;

  localparam int DEFAULT_STACK_DEPTH = 64;

  localparam int DATA_W  = 32;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int LEVEL_W = 7;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // result word: popped, minimum, empty flag, fill level
  localparam int RES_W = 2 * DATA_W + 1 + LEVEL_W;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_CALC
  } state_t;

endpackage

`default_nettype wire

@@ sv/msk_ram.sv @@
`default_nettype none

module msk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/min_tracking_stack.sv @@
`default_nettype none

// Bounded stack of signed 32-bit values that also reports its minimum.
//
// Input channel (s_*): one word per operation. s_tuser carries the
// operation (push, pop, clear; the unused code only reports the stack),
// s_tdata the value to push, ignored by the other operations.
// Output channel (m_*): exactly one word per operation, in order. m_tuser
// carries the status (ok, pop on empty, push on full refused), m_tdata the
// popped value, the minimum held, the empty flag and the fill level.
//
// Each level stores its value and the minimum of itself and all levels
// below it, in two RAMs with a registered read. The accept cycle reads
// the top level (and the level below it for a pop); the calc state then
// forms the result and, once the output register is free, writes back a
// push and loads the output register. A new operation is accepted only
// once the last has finished; m_tvalid is set by that register load.
//
// Reset (rst, synchronous) empties the stack and drops any pending result;
// RAM contents are not cleared, they are only used below the fill count.
// A stalled receiver holds the result in the output register; one more
// operation is accepted and waits, read done, until the register frees.

module min_tracking_stack #(
  parameter int STACK_DEPTH = msk_pkg::DEFAULT_STACK_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // [31:0] push_value
  input  wire logic [msk_pkg::DATA_W-1:0] s_tdata,
  // [1:0] operation
  input  wire logic [msk_pkg::OP_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // [31:0] popped_value, [63:32] current_minimum, [64] stack_empty,
  // [71:65] fill_level
  output logic [msk_pkg::RES_W-1:0]       m_tdata,
  // [1:0] status
  output logic [msk_pkg::STAT_W-1:0]      m_tuser
);

  import msk_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE        = CW'(1);
  localparam logic [CW-1:0] TWO        = CW'(2);

  state_t state, state_next;

  logic [CW-1:0]     fill, fill_next;
  logic [OP_W-1:0]   op_reg;
  logic [DATA_W-1:0] val_reg;

  logic accept;
  logic finish;

  // RAM ports
  logic [AW-1:0]     val_rd_addr, min_rd_addr, wr_addr;
  logic [DATA_W-1:0] val_rd_data, min_rd_data;
  logic [DATA_W-1:0] min_wr_data;
  logic              push_write;

  // result being formed
  logic [STAT_W-1:0]        res_status;
  logic signed [DATA_W-1:0] res_popped, res_min;
  logic signed [DATA_W-1:0] below_min, push_val;

  logic [CW-1:0] fill_m1, fill_m2;

  assign fill_m1 = fill - ONE;
  assign fill_m2 = fill - TWO;

  // ---------------------------------------------------------------- control
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_CALC;
      end
      ST_CALC: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    finish   = (state == ST_CALC) && (!m_tvalid || m_tready);
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (finish) fill <= fill_next;
    end
  end

  // hold the operation while its read is in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      op_reg  <= s_tuser;
      val_reg <= s_tdata;
    end
  end

  // ---------------------------------------------------------------- reads
  // Values: read the top level. Minimums: for a pop read the level that
  // becomes the top, otherwise the current top.
  always_comb begin
    val_rd_addr = fill_m1[AW-1:0];
    if (s_tuser == OP_POP) begin
      min_rd_addr = fill_m2[AW-1:0];
    end else begin
      min_rd_addr = fill_m1[AW-1:0];
    end
  end

  msk_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_values (
    .clk    (clk),
    .wr_en  (push_write),
    .wr_addr(wr_addr),
    .wr_data(val_reg),
    .rd_en  (accept),
    .rd_addr(val_rd_addr),
    .rd_data(val_rd_data)
  );

  msk_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_minimums (
    .clk    (clk),
    .wr_en  (push_write),
    .wr_addr(wr_addr),
    .wr_data(min_wr_data),
    .rd_en  (accept),
    .rd_addr(min_rd_addr),
    .rd_data(min_rd_data)
  );

  // ---------------------------------------------------------------- modify
  assign below_min = min_rd_data;
  assign push_val  = val_reg;
  assign wr_addr   = fill[AW-1:0];

  always_comb begin
    res_status  = STAT_OK;
    res_popped  = '0;
    res_min     = '0;
    fill_next   = fill;
    push_write  = 1'b0;
    min_wr_data = val_reg;
    case (op_reg)
      OP_PUSH: begin
        if (fill == FULL_COUNT) begin
          // refuse; report the unchanged stack
          res_status = STAT_FULL;
          res_min    = below_min;
        end else begin
          if ((fill != '0) && (below_min < push_val)) begin
            res_min = below_min;
          end else begin
            res_min = push_val;
          end
          min_wr_data = res_min;
          push_write  = finish;
          fill_next   = fill + ONE;
        end
      end
      OP_POP: begin
        if (fill == '0) begin
          res_status = STAT_EMPTY;
        end else begin
          res_popped = val_rd_data;
          fill_next  = fill_m1;
          if (fill != ONE) res_min = below_min;
        end
      end
      OP_CLEAR: begin
        fill_next = '0;
      end
      default: begin
        // no operation: report the stack as it is
        if (fill != '0) res_min = below_min;
      end
    endcase
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tuser <= res_status;
      m_tdata <= {LEVEL_W'(fill_next), (fill_next == '0), res_min, res_popped};
    end
  end

endmodule

`default_nettype wire
